FILE: sv/hrfp_pkg.sv
// Shared constants, types and helpers for the HTTP response framing parser.
package hrfp_pkg;

   localparam int MAX_LINE_DEFAULT = 256;
   localparam int POS_W = 13;

   localparam logic [1:0] OP_DATA    = 2'd0;
   localparam logic [1:0] OP_EOS     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [2:0] PH_STATUS  = 3'd0;
   localparam logic [2:0] PH_HEADERS = 3'd1;
   localparam logic [2:0] PH_BODY    = 3'd2;
   localparam logic [2:0] PH_DONE    = 3'd3;
   localparam logic [2:0] PH_FAILED  = 3'd4;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_STATUS    = 3'd1;
   localparam logic [2:0] ERR_ENCODING  = 3'd2;
   localparam logic [2:0] ERR_LINE_LONG = 3'd3;
   localparam logic [2:0] ERR_CHUNK     = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED = 3'd5;

   localparam logic [31:0] LEN_UNKNOWN = 32'hFFFF_FFFF;

   // Header names of interest, lower case, in the low bytes with the first character highest.
   localparam int NUM_NAMES = 5;
   localparam int NAME_CL = 0;
   localparam int NAME_TE = 1;
   localparam logic [135:0] NAME_TEXT [NUM_NAMES] = '{
      136'("content-length"), 136'("transfer-encoding"), 136'("etag"),
      136'("last-modified"), 136'("location")};
   localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{5'd14, 5'd17, 5'd4, 5'd13, 5'd8};
   localparam logic [135:0] TEXT_CHUNKED = 136'("chunked");
   localparam logic [39:0] TEXT_HTTP = "HTTP/";

   typedef struct packed {
      logic latch;
      logic exec;
   } hrfp_cmd_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   // Character i of an n-character string held in the low bytes of s.
   function automatic logic [7:0] pick(input logic [135:0] s, input logic [4:0] n,
                                       input logic [4:0] i);
      logic [135:0] t;
      t = s >> {n - 5'd1 - i, 3'b000};
      return t[7:0];
   endfunction

endpackage

FILE: sv/hrfp_ctrl.sv
// Handshake controller: takes a beat, runs it through the datapath, holds the result.
module hrfp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hrfp_pkg::hrfp_cmd_type cmd
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The result register must be free, or emptied this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/hrfp_datapath.sv
// Parser datapath: line scanners, header decoding, body framing and result register.
module hrfp_datapath #(
   parameter int MAX_LINE = hrfp_pkg::MAX_LINE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hrfp_pkg::hrfp_cmd_type cmd,
   input  logic [1:0]             req_operation,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_body_valid,
   output logic [7:0]             rsp_body_byte,
   output logic [2:0]             rsp_phase,
   output logic [2:0]             rsp_error_code,
   output logic [9:0]             rsp_status_code,
   output logic [31:0]            rsp_body_count
);

   localparam int LW = $clog2(MAX_LINE);
   localparam logic [LW-1:0] LINE_LAST = LW'(MAX_LINE - 1);
   localparam int NUM_NAMES_L = hrfp_pkg::NUM_NAMES;

   typedef enum logic [2:0] {SC_PRE, SC_SP, SC_DIG, SC_END, SC_BAD} scan_type;
   typedef enum logic [1:0] {CL_WS, CL_DIG, CL_STOP} clen_type;
   typedef enum logic [1:0] {TE_LEAD, TE_MATCH, TE_TRAIL, TE_BAD} tenc_type;
   typedef enum logic [2:0] {CK_SIZE, CK_EXT, CK_DATA, CK_DEND, CK_TRAILER} chunk_type;

   logic [1:0]  op_ff;
   logic [7:0]  c_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  error_ff, error_in;
   logic [9:0]  status_ff, status_in;
   logic [LW-1:0] len_ff, len_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] decl_ff, decl_in;
   logic        chunked_ff, chunked_in;
   chunk_type   ck_ff, ck_in;
   logic [31:0] rem_ff, rem_in;
   logic        digit_ff, digit_in;
   logic        trail_empty_ff, trail_empty_in;
   logic [31:0] count_ff, count_in;

   logic        http_ok_ff, http_ok_in;
   scan_type    scan_ff, scan_in;
   logic [9:0]  sval_ff, sval_in;
   logic [NUM_NAMES_L-1:0] match_ff, match_in;
   clen_type    cl_ff, cl_in;
   logic        neg_ff, neg_in;
   logic [31:0] acc_ff, acc_in;
   tenc_type    te_ff, te_in;
   logic [2:0]  tek_ff, tek_in;

   logic        bv;
   logic        line_clear;
   logic        needed;
   logic [hrfp_pkg::POS_W-1:0] pos;
   logic [31:0] cnt_inc;
   logic [3:0]  dval;
   logic        is_dec, is_hex;
   logic [3:0]  hval;
   logic [13:0] stmp;
   logic [35:0] ctmp;
   logic        cl_ws, te_ws;
   logic [7:0]  fc;

   assign pos     = hrfp_pkg::POS_W'(len_ff);
   assign cnt_inc = count_ff + 32'd1;
   assign fc      = hrfp_pkg::fold(c_ff);
   assign is_dec  = (c_ff >= "0" && c_ff <= "9");
   assign dval    = c_ff[3:0];
   assign stmp    = 14'(sval_ff) * 14'd10 + 14'(dval);
   assign ctmp    = 36'(acc_ff) * 36'd10 + 36'(dval);
   assign cl_ws   = (c_ff == 8'd32 || c_ff == 8'd9 || c_ff == 8'd11 || c_ff == 8'd12);
   assign te_ws   = (c_ff == 8'd32 || c_ff == 8'd9);

   always_comb begin
      is_hex = 1'b1;
      hval   = 4'd0;
      if (is_dec) begin
         hval = c_ff[3:0];
      end else if (fc >= "a" && fc <= "f") begin
         hval = 4'(fc - "a" + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      error_in       = error_ff;
      status_in      = status_ff;
      len_in         = len_ff;
      ovf_in         = ovf_ff;
      decl_in        = decl_ff;
      chunked_in     = chunked_ff;
      ck_in          = ck_ff;
      rem_in         = rem_ff;
      digit_in       = digit_ff;
      trail_empty_in = trail_empty_ff;
      count_in       = count_ff;
      http_ok_in     = http_ok_ff;
      scan_in        = scan_ff;
      sval_in        = sval_ff;
      match_in       = match_ff;
      cl_in          = cl_ff;
      neg_in         = neg_ff;
      acc_in         = acc_ff;
      te_in          = te_ff;
      tek_in         = tek_ff;
      bv             = 1'b0;
      line_clear     = 1'b0;
      needed         = 1'b0;

      if (op_ff == hrfp_pkg::OP_RESTART) begin
         phase_in       = hrfp_pkg::PH_STATUS;
         error_in       = hrfp_pkg::ERR_NONE;
         status_in      = '0;
         decl_in        = hrfp_pkg::LEN_UNKNOWN;
         chunked_in     = 1'b0;
         ck_in          = CK_SIZE;
         rem_in         = '0;
         digit_in       = 1'b0;
         trail_empty_in = 1'b1;
         count_in       = '0;
         line_clear     = 1'b1;
      end else if (phase_ff == hrfp_pkg::PH_STATUS || phase_ff == hrfp_pkg::PH_HEADERS ||
                   phase_ff == hrfp_pkg::PH_BODY) begin
         if (op_ff == hrfp_pkg::OP_EOS) begin
            if (phase_ff == hrfp_pkg::PH_BODY && decl_ff == hrfp_pkg::LEN_UNKNOWN &&
                !chunked_ff) begin
               phase_in = hrfp_pkg::PH_DONE;
            end else begin
               phase_in = hrfp_pkg::PH_FAILED;
               error_in = hrfp_pkg::ERR_TRUNCATED;
            end
         end else if (op_ff == hrfp_pkg::OP_DATA) begin
            if (phase_ff == hrfp_pkg::PH_BODY) begin
               if (chunked_ff) begin
                  unique case (ck_ff)
                     CK_DATA: begin
                        bv       = 1'b1;
                        count_in = cnt_inc;
                        rem_in   = rem_ff - 32'd1;
                        if (rem_ff == 32'd1) ck_in = CK_DEND;
                     end
                     CK_SIZE, CK_EXT: begin
                        if (ck_ff == CK_SIZE && is_hex) begin
                           if (rem_ff[31:28] != 4'd0) begin
                              phase_in = hrfp_pkg::PH_FAILED;
                              error_in = hrfp_pkg::ERR_CHUNK;
                           end else begin
                              rem_in   = {rem_ff[27:0], hval};
                              digit_in = 1'b1;
                           end
                        end else if (c_ff == 8'h0A) begin
                           if (!digit_ff) begin
                              phase_in = hrfp_pkg::PH_FAILED;
                              error_in = hrfp_pkg::ERR_CHUNK;
                           end else begin
                              digit_in = 1'b0;
                              if (rem_ff == 32'd0) begin
                                 ck_in          = CK_TRAILER;
                                 trail_empty_in = 1'b1;
                              end else begin
                                 ck_in = CK_DATA;
                              end
                           end
                        end else if (ck_ff == CK_SIZE) begin
                           if (c_ff == ";" || te_ws) begin
                              ck_in = CK_EXT;
                           end else if (c_ff != 8'h0D) begin
                              phase_in = hrfp_pkg::PH_FAILED;
                              error_in = hrfp_pkg::ERR_CHUNK;
                           end
                        end
                     end
                     CK_DEND: begin
                        if (c_ff == 8'h0A) begin
                           ck_in  = CK_SIZE;
                           rem_in = '0;
                        end else if (c_ff != 8'h0D) begin
                           phase_in = hrfp_pkg::PH_FAILED;
                           error_in = hrfp_pkg::ERR_CHUNK;
                        end
                     end
                     CK_TRAILER: begin
                        if (c_ff == 8'h0A) begin
                           if (trail_empty_ff) phase_in = hrfp_pkg::PH_DONE;
                           else trail_empty_in = 1'b1;
                        end else if (c_ff != 8'h0D) begin
                           trail_empty_in = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else if (decl_ff != hrfp_pkg::LEN_UNKNOWN) begin
                  if (count_ff >= decl_ff) begin
                     phase_in = hrfp_pkg::PH_DONE;
                  end else begin
                     bv       = 1'b1;
                     count_in = cnt_inc;
                     if (cnt_inc >= decl_ff) phase_in = hrfp_pkg::PH_DONE;
                  end
               end else begin
                  bv       = 1'b1;
                  count_in = cnt_inc;
               end
            end else if (c_ff == 8'h0D) begin
               // Carriage returns never reach the line scanners.
            end else if (c_ff != 8'h0A) begin
               if (len_ff == LINE_LAST) begin
                  ovf_in = 1'b1;
               end else begin
                  len_in = len_ff + 1'b1;
                  // Status line scanner.
                  if (pos < 5) begin
                     if (c_ff != hrfp_pkg::pick(136'(hrfp_pkg::TEXT_HTTP), 5'd5, pos[4:0]))
                        http_ok_in = 1'b0;
                  end
                  // Only the first run of digits after the spaces counts.
                  unique case (scan_ff)
                     SC_PRE: if (c_ff == 8'd32) scan_in = SC_SP;
                     SC_SP: begin
                        if (is_dec) begin
                           scan_in = SC_DIG;
                           sval_in = 10'(dval);
                        end else if (c_ff != 8'd32) begin
                           scan_in = SC_BAD;
                        end
                     end
                     SC_DIG: begin
                        if (is_dec) sval_in = (stmp > 14'd1023) ? 10'd1023 : stmp[9:0];
                        else scan_in = SC_END;
                     end
                     SC_END: begin
                     end
                     SC_BAD: begin
                     end
                     default: begin
                     end
                  endcase
                  // Header name matching.
                  for (int k = 0; k < NUM_NAMES_L; k++) begin
                     if (pos < hrfp_pkg::POS_W'(hrfp_pkg::NAME_LEN[k])) begin
                        if (fc != hrfp_pkg::pick(hrfp_pkg::NAME_TEXT[k], hrfp_pkg::NAME_LEN[k],
                                                 pos[4:0]))
                           match_in[k] = 1'b0;
                     end else if (pos == hrfp_pkg::POS_W'(hrfp_pkg::NAME_LEN[k])) begin
                        if (c_ff != ":") match_in[k] = 1'b0;
                     end
                  end
                  // Content-Length value.
                  if (pos >= 15) begin
                     unique case (cl_ff)
                        CL_WS: begin
                           if (c_ff == "+" || c_ff == "-") begin
                              neg_in = (c_ff == "-");
                              cl_in  = CL_DIG;
                           end else if (is_dec) begin
                              acc_in = 32'(dval);
                              cl_in  = CL_DIG;
                           end else if (!cl_ws) begin
                              cl_in = CL_STOP;
                           end
                        end
                        CL_DIG: begin
                           if (is_dec) begin
                              acc_in = (ctmp > 36'h0_8000_0000) ? 32'h8000_0000 : ctmp[31:0];
                           end else begin
                              cl_in = CL_STOP;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  // Transfer-Encoding value.
                  if (pos >= 18) begin
                     unique case (te_ff)
                        TE_LEAD: begin
                           if (fc == "c") begin
                              te_in  = TE_MATCH;
                              tek_in = 3'd1;
                           end else if (!te_ws) begin
                              te_in = TE_BAD;
                           end
                        end
                        TE_MATCH: begin
                           if (tek_ff == 3'd7) begin
                              te_in = te_ws ? TE_TRAIL : TE_BAD;
                           end else if (fc == hrfp_pkg::pick(hrfp_pkg::TEXT_CHUNKED, 5'd7,
                                                             {2'b00, tek_ff})) begin
                              tek_in = tek_ff + 3'd1;
                           end else begin
                              te_in = TE_BAD;
                           end
                        end
                        TE_TRAIL: if (!te_ws) te_in = TE_BAD;
                        TE_BAD: begin
                        end
                     endcase
                  end
               end
            end else begin
               // End of line.
               line_clear = 1'b1;
               if (ovf_ff) begin
                  needed = (phase_ff == hrfp_pkg::PH_STATUS);
                  for (int k = 0; k < NUM_NAMES_L; k++) begin
                     if (match_ff[k] && pos > hrfp_pkg::POS_W'(hrfp_pkg::NAME_LEN[k]))
                        needed = 1'b1;
                  end
                  if (needed) begin
                     phase_in = hrfp_pkg::PH_FAILED;
                     error_in = hrfp_pkg::ERR_LINE_LONG;
                  end
               end else if (phase_ff == hrfp_pkg::PH_STATUS) begin
                  if (!http_ok_ff || pos < 5 || (scan_ff != SC_DIG && scan_ff != SC_END)) begin
                     phase_in = hrfp_pkg::PH_FAILED;
                     error_in = hrfp_pkg::ERR_STATUS;
                  end else begin
                     status_in = sval_ff;
                     if (sval_ff < 10'd100 || sval_ff > 10'd599) begin
                        phase_in = hrfp_pkg::PH_FAILED;
                        error_in = hrfp_pkg::ERR_STATUS;
                     end else begin
                        phase_in = hrfp_pkg::PH_HEADERS;
                     end
                  end
               end else if (pos == 0) begin
                  if (status_ff == 10'd304 || status_ff == 10'd204 ||
                      (!chunked_ff && decl_ff == 32'd0))
                     phase_in = hrfp_pkg::PH_DONE;
                  else
                     phase_in = hrfp_pkg::PH_BODY;
               end else if (match_ff[hrfp_pkg::NAME_CL] && pos >= 15) begin
                  if (neg_ff && acc_ff != 32'd0) decl_in = hrfp_pkg::LEN_UNKNOWN;
                  else decl_in = acc_ff[31] ? 32'h7FFF_FFFF : acc_ff;
               end else if (match_ff[hrfp_pkg::NAME_TE] && pos >= 18) begin
                  if ((te_ff == TE_MATCH && tek_ff == 3'd7) || te_ff == TE_TRAIL) begin
                     chunked_in = 1'b1;
                  end else begin
                     phase_in = hrfp_pkg::PH_FAILED;
                     error_in = hrfp_pkg::ERR_ENCODING;
                  end
               end
            end
         end
      end

      if (line_clear) begin
         len_in     = '0;
         ovf_in     = 1'b0;
         http_ok_in = 1'b1;
         scan_in    = SC_PRE;
         sval_in    = '0;
         match_in   = '1;
         cl_in      = CL_WS;
         neg_in     = 1'b0;
         acc_in     = '0;
         te_in      = TE_LEAD;
         tek_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_operation;
         c_ff  <= req_data_byte;
      end
      if (cmd.exec) begin
         rsp_body_valid  <= bv;
         rsp_body_byte   <= bv ? c_ff : 8'd0;
         rsp_phase       <= phase_in;
         rsp_error_code  <= error_in;
         rsp_status_code <= status_in;
         rsp_body_count  <= count_in;
      end
      if (reset) begin
         phase_ff       <= hrfp_pkg::PH_STATUS;
         error_ff       <= hrfp_pkg::ERR_NONE;
         status_ff      <= '0;
         len_ff         <= '0;
         ovf_ff         <= 1'b0;
         decl_ff        <= hrfp_pkg::LEN_UNKNOWN;
         chunked_ff     <= 1'b0;
         ck_ff          <= CK_SIZE;
         rem_ff         <= '0;
         digit_ff       <= 1'b0;
         trail_empty_ff <= 1'b1;
         count_ff       <= '0;
         http_ok_ff     <= 1'b1;
         scan_ff        <= SC_PRE;
         sval_ff        <= '0;
         match_ff       <= '1;
         cl_ff          <= CL_WS;
         neg_ff         <= 1'b0;
         acc_ff         <= '0;
         te_ff          <= TE_LEAD;
         tek_ff         <= '0;
      end else if (cmd.exec) begin
         phase_ff       <= phase_in;
         error_ff       <= error_in;
         status_ff      <= status_in;
         len_ff         <= len_in;
         ovf_ff         <= ovf_in;
         decl_ff        <= decl_in;
         chunked_ff     <= chunked_in;
         ck_ff          <= ck_in;
         rem_ff         <= rem_in;
         digit_ff       <= digit_in;
         trail_empty_ff <= trail_empty_in;
         count_ff       <= count_in;
         http_ok_ff     <= http_ok_in;
         scan_ff        <= scan_in;
         sval_ff        <= sval_in;
         match_ff       <= match_in;
         cl_ff          <= cl_in;
         neg_ff         <= neg_in;
         acc_ff         <= acc_in;
         te_ff          <= te_in;
         tek_ff         <= tek_in;
      end
   end

endmodule

FILE: sv/http_response_framing_parser_core.sv
// Top level of the HTTP/1.1 response framing parser.
// Each request beat (a byte, end of stream or restart) is first captured; then the
// datapath updates the parser state and loads the result register, once that register
// is free or being emptied, and no new beat is taken before then. Header lines are
// decoded on the fly as their bytes arrive, so the closing line feed is handled like any
// other byte. Every request beat yields exactly one result beat; a waiting result does not
// stop the next request from being captured. Lines longer than MAX_LINE-1 bytes keep only
// their first MAX_LINE-1 bytes; a status or matched header line that overflows fails.
module http_response_framing_parser_core #(
   parameter int MAX_LINE = hrfp_pkg::MAX_LINE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_body_valid,
   output logic [7:0]  rsp_body_byte,
   output logic [2:0]  rsp_phase,
   output logic [2:0]  rsp_error_code,
   output logic [9:0]  rsp_status_code,
   output logic [31:0] rsp_body_count
);

   hrfp_pkg::hrfp_cmd_type cmd;

   hrfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   hrfp_datapath #(.MAX_LINE(MAX_LINE)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .rsp_body_valid  (rsp_body_valid),
      .rsp_body_byte   (rsp_body_byte),
      .rsp_phase       (rsp_phase),
      .rsp_error_code  (rsp_error_code),
      .rsp_status_code (rsp_status_code),
      .rsp_body_count  (rsp_body_count)
   );

endmodule

FILE: sv/hrfp_checker.sv
// Port-level checks for the response framing parser, bound to the top level.
module hrfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_body_valid,
   input logic [7:0]  rsp_body_byte,
   input logic [2:0]  rsp_phase,
   input logic [2:0]  rsp_error_code,
   input logic [9:0]  rsp_status_code,
   input logic [31:0] rsp_body_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase) && $stable(rsp_body_count)
                                 && $stable(rsp_status_code) && $stable(rsp_body_byte))
      else $error("stalled result beat changed");

   a_one_beat_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request beat taken while one is in work");

   a_body_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_valid |-> rsp_phase == hrfp_pkg::PH_BODY
                                      || rsp_phase == hrfp_pkg::PH_DONE)
      else $error("body byte outside the body");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_body_valid |-> rsp_body_byte == 8'd0)
      else $error("body byte not cleared");

   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code != hrfp_pkg::ERR_NONE) == (rsp_phase == hrfp_pkg::PH_FAILED))
      else $error("error code and failed phase disagree");

endmodule

bind http_response_framing_parser_core hrfp_checker u_hrfp_checker (.*);
